>>> src/pip_pkg.sv
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W = 24;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int VTX_W = 2 * COORD_W;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef struct packed {
    logic valid;
    logic toggle;
  } pip_hit_t;

endpackage

>>> src/pip_req_if.sv
interface pip_req_if import pip_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;

  modport source (output valid, output cmd, output point_x, output point_y, input ready);
  modport sink (input valid, input cmd, input point_x, input point_y, output ready);
endinterface

>>> src/pip_rsp_if.sv
interface pip_rsp_if import pip_pkg::*; ();
  logic valid;
  logic ready;
  logic inside_res;
  logic truncated;

  modport source (output valid, output inside_res, output truncated, input ready);
  modport sink (input valid, input inside_res, input truncated, output ready);
endinterface

>>> src/pip_edge_unit.sv
module pip_edge_unit import pip_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] cur_x,
  input  logic signed [COORD_W-1:0] cur_y,
  input  logic signed [COORD_W-1:0] prev_x,
  input  logic signed [COORD_W-1:0] prev_y,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  output pip_hit_t                  hit
);

  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dxp;
  logic signed [DIFF_W-1:0] dxj;
  logic signed [DIFF_W-1:0] dyp;
  logic                     straddle_next;

  logic                     va;
  logic                     straddle;
  logic                     dy_pos;
  logic signed [PROD_W-1:0] lhs;
  logic signed [PROD_W-1:0] rhs;

  assign dy  = {prev_y[COORD_W-1], prev_y} - {cur_y[COORD_W-1], cur_y};
  assign dxp = {px[COORD_W-1], px} - {cur_x[COORD_W-1], cur_x};
  assign dxj = {prev_x[COORD_W-1], prev_x} - {cur_x[COORD_W-1], cur_x};
  assign dyp = {py[COORD_W-1], py} - {cur_y[COORD_W-1], cur_y};
  assign straddle_next = (cur_y > py) != (prev_y > py);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      straddle <= straddle_next;
      dy_pos   <= ~dy[DIFF_W-1];
      lhs      <= PROD_W'(dxp) * PROD_W'(dy);
      rhs      <= PROD_W'(dxj) * PROD_W'(dyp);
    end
  end

  assign hit.valid  = va;
  assign hit.toggle = straddle & (dy_pos ? (lhs < rhs) : (lhs > rhs));

endmodule

>>> src/point_in_polygon_test_core.sv
// Point-in-polygon test, even-odd crossing rule, signed 24-bit coordinates.
// Channels: req (sink) carries cmd, point_x, point_y; rsp (source) carries
// inside_res and truncated. A word moves when valid and ready are both high.
// cmd 0 starts a new polygon with the vertex, cmd 1 appends a vertex, cmd 2
// queries the point and yields one rsp word; cmd 3 is ignored.
// Vertices live in one 64 x 48-bit synchronous RAM; appends past the limit
// are dropped and flagged in truncated until the next start.
// A query reads the closing vertex, then walks the vertices one per cycle
// through the RAM read port into the edge unit (registered products, then
// compare). req.ready is low during a query.
// The rsp word sits in an output register; vertex words are still taken
// while it waits, and a later query finishes only once rsp is free.
// Reset (rst, synchronous) empties the polygon and clears the flag; RAM
// contents are not cleared and need no clearing pass.
module point_in_polygon_test_core import pip_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pip_req_if.sink   req,
  pip_rsp_if.source rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                state;
  logic [CNT_W-1:0]          vcount;
  logic [CNT_W-1:0]          vcount_m1;
  logic [CNT_W-1:0]          idx;
  logic                      ovf;
  logic                      parity;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;

  logic [VTX_W-1:0]          vmem [MAX_VERTICES];
  logic [VTX_W-1:0]          rd_data;
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;

  logic                      v1;
  logic                      first1;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;
  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  pip_hit_t                  hit;

  logic                      accept;
  logic                      issue_done;
  logic                      has_room;
  logic                      out_free;
  logic                      out_valid;
  logic                      out_inside;
  logic                      out_trunc;

  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid & req.ready;
  assign has_room   = vcount < CNT_W'(MAX_VERTICES);
  assign vcount_m1  = vcount - CNT_W'(1);
  assign issue_done = (idx == vcount);
  assign out_free   = ~out_valid | rsp.ready;

  assign wr_en   = accept & ((req.cmd == CMD_START) | ((req.cmd == CMD_APPEND) & has_room));
  assign wr_addr = (req.cmd == CMD_START) ? '0 : vcount[ADDR_W-1:0];

  assign rd_en   = (accept & (req.cmd == CMD_QUERY) & (vcount != '0))
                 | ((state == ST_RUN) & ~issue_done);
  assign rd_addr = (state == ST_IDLE) ? vcount_m1[ADDR_W-1:0] : idx[ADDR_W-1:0];

  assign cur_x = rd_data[VTX_W-1:COORD_W];
  assign cur_y = rd_data[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[wr_addr] <= {req.point_x, req.point_y};
    end
    if (rd_en) begin
      rd_data <= vmem[rd_addr];
    end
  end

  pip_edge_unit u_edge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1 & ~first1),
    .cur_x    (cur_x),
    .cur_y    (cur_y),
    .prev_x   (prev_x),
    .prev_y   (prev_y),
    .px       (px),
    .py       (py),
    .hit      (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vcount    <= '0;
      ovf       <= 1'b0;
      idx       <= '0;
      parity    <= 1'b0;
      v1        <= 1'b0;
      first1    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1     <= rd_en;
      first1 <= (state == ST_IDLE);
      if ((state == ST_DONE) & out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (accept & (req.cmd == CMD_QUERY)) begin
        parity <= 1'b0;
      end else if (hit.valid & hit.toggle) begin
        parity <= ~parity;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.cmd)
              CMD_START: begin
                vcount <= CNT_W'(1);
                ovf    <= 1'b0;
              end
              CMD_APPEND: begin
                if (has_room) begin
                  vcount <= vcount + CNT_W'(1);
                end else begin
                  ovf <= 1'b1;
                end
              end
              CMD_QUERY: begin
                idx    <= '0;
                state  <= (vcount == '0) ? ST_DONE : ST_RUN;
              end
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          if (~issue_done) begin
            idx <= idx + CNT_W'(1);
          end else if (~v1 & ~hit.valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept & (req.cmd == CMD_QUERY)) begin
      px <= req.point_x;
      py <= req.point_y;
    end
    if (v1) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if ((state == ST_DONE) & out_free) begin
      out_inside <= parity;
      out_trunc  <= ovf;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.inside_res = out_inside;
  assign rsp.truncated  = out_trunc;

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    vcount <= CNT_W'(MAX_VERTICES))
    else $error("vertex count past limit");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> vcount != '0)
    else $error("RAM read with empty polygon");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> ~wr_en)
    else $error("vertex write during query walk");

  a_drained_at_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (~v1 & ~hit.valid))
    else $error("result taken before edge pipeline drained");

  a_hit_follows_read: assert property (@(posedge clk) disable iff (rst)
    hit.valid |-> $past(v1))
    else $error("edge result without RAM read");

endmodule

>>> tb/pip_crossing_checker.sv
`timescale 1ns / 100ps

module pip_crossing_checker import pip_pkg::*; (
  input  logic clk,
  input  logic rst,
  pip_req_if   req,
  pip_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic inside_res;
    logic truncated;
  } pip_answer_t;

  logic signed [COORD_W-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] poly_y [MAX_VERTICES];
  int unsigned poly_len;
  bit dropped;
  pip_answer_t answers_due [$];

  initial begin
    fail_count = 0;
    pending = 0;
    poly_len = 0;
    dropped = 1'b0;
  end

  // Even-odd ray cast toward +x, crossing compared by cross-multiplication.
  function automatic bit ray_parity(input logic signed [COORD_W-1:0] px,
                                    input logic signed [COORD_W-1:0] py);
    bit odd;
    int unsigned j;
    longint pxl, pyl, xi, yi, xj, yj, dy, lhs, rhs;
    odd = 1'b0;
    pxl = px;
    pyl = py;
    if (poly_len == 0) return 1'b0;
    j = poly_len - 1;
    for (int unsigned i = 0; i < poly_len; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if ((yi > pyl) != (yj > pyl)) begin
        dy = yj - yi;
        lhs = (pxl - xi) * dy;
        rhs = (xj - xi) * (pyl - yi);
        if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) odd = !odd;
      end
      j = i;
    end
    return odd;
  endfunction

  function automatic void store_vertex(input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y);
    if (poly_len < MAX_VERTICES) begin
      poly_x[poly_len] = x;
      poly_y[poly_len] = y;
      poly_len++;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("checker: %s", msg);
  endtask

  always @(posedge clk) begin
    pip_answer_t want;
    if (rst) begin
      poly_len = 0;
      dropped = 1'b0;
      answers_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (answers_due.size() == 0) begin
          note_failure($sformatf("unexpected word inside=%0b truncated=%0b",
                                 rsp.inside_res, rsp.truncated));
        end else begin
          want = answers_due.pop_front();
          if (rsp.inside_res !== want.inside_res || rsp.truncated !== want.truncated)
            note_failure($sformatf(
              "mismatch: expected inside=%0b truncated=%0b, got inside=%0b truncated=%0b",
              want.inside_res, want.truncated, rsp.inside_res, rsp.truncated));
        end
      end
      if (req.valid && req.ready) begin
        case (req.cmd)
          CMD_START: begin
            poly_len = 0;
            dropped = 1'b0;
            store_vertex(req.point_x, req.point_y);
          end
          CMD_APPEND: begin
            store_vertex(req.point_x, req.point_y);
          end
          CMD_QUERY: begin
            want.inside_res = ray_parity(req.point_x, req.point_y);
            want.truncated = dropped;
            answers_due.insert(answers_due.size(), want);
          end
          default: begin
          end
        endcase
      end
    end
    pending = answers_due.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pip_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;
  localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
  localparam int RANDOM_WORDS = 550;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = MAX_VERTICES + 16;
  localparam int CYCLE_LIMIT = 500000;

  logic clk;
  logic rst;
  int fail_count;
  int pending;
  int words_sent;
  int cycles;
  bit steady;
  bit hold_done;

  pip_req_if req();
  pip_rsp_if rsp();

  point_in_polygon_test_core uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  pip_crossing_checker watcher (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(input bit wide, input int span);
    logic [31:0] raw;
    if (wide) begin
      raw = $urandom();
      return raw[COORD_W-1:0];
    end
    return COORD_W'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.point_x <= x;
    req.point_y <= y;
    do @(posedge clk); while (!req.ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off to back up the query path.
  initial begin
    int stall;
    stall = 0;
    hold_done = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_sent >= 200) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        rsp.ready <= 1'b1;
      end else if (stall > 0) begin
        rsp.ready <= 1'b0;
        stall--;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    int base, n, queries, span, r;
    bit wide;
    logic [1:0] lead;
    words_sent = 0;
    steady = 1'b0;
    req.valid = 1'b0;
    req.cmd = CMD_START;
    req.point_x = '0;
    req.point_y = '0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty polygon, append with no start, one-vertex polygon, unused cmd
    send_word(CMD_QUERY, 24'sd0, 24'sd0);
    send_word(CMD_APPEND, C_MAX, C_MIN);
    send_word(CMD_QUERY, C_MIN, C_MIN);
    send_word(CMD_UNUSED, C_MIN, C_MAX);
    // full-range square
    send_word(CMD_START, C_MIN, C_MIN);
    send_word(CMD_APPEND, C_MAX, C_MIN);
    send_word(CMD_APPEND, C_MAX, C_MAX);
    send_word(CMD_APPEND, C_MIN, C_MAX);
    send_word(CMD_QUERY, 24'sd0, 24'sd0);
    send_word(CMD_QUERY, C_MIN, 24'sd0);
    send_word(CMD_QUERY, C_MAX, C_MAX);
    send_word(CMD_QUERY, C_MIN, C_MIN);
    send_word(CMD_QUERY, 24'sd0, C_MIN);
    send_word(CMD_QUERY, -24'sd1, -24'sd1);
    // small triangle: points on vertex y, on an edge, on a vertex
    send_word(CMD_START, 24'sd0, 24'sd0);
    send_word(CMD_APPEND, 24'sd10, 24'sd10);
    send_word(CMD_APPEND, -24'sd10, 24'sd10);
    send_word(CMD_QUERY, 24'sd0, 24'sd5);
    send_word(CMD_QUERY, 24'sd5, 24'sd5);
    send_word(CMD_QUERY, -24'sd5, 24'sd5);
    send_word(CMD_QUERY, -24'sd20, 24'sd10);
    send_word(CMD_QUERY, 24'sd0, 24'sd0);
    send_word(CMD_UNUSED, 24'sd5, 24'sd5);

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      steady = ($urandom_range(0, 3) == 0);
      wide = ($urandom_range(0, 2) == 0);
      span = $urandom_range(4, 40);
      r = $urandom_range(0, 99);
      if (r < 6) n = $urandom_range(62, 70);
      else if (r < 14) n = $urandom_range(1, 2);
      else n = $urandom_range(3, 12);
      lead = ($urandom_range(0, 9) == 0) ? CMD_APPEND : CMD_START;
      for (int k = 0; k < n; k++)
        send_word((k == 0) ? lead : CMD_APPEND, pick_coord(wide, span), pick_coord(wide, span));
      if ($urandom_range(0, 9) == 0)
        send_word(CMD_UNUSED, pick_coord(1'b1, span), pick_coord(1'b1, span));
      queries = $urandom_range(1, 6);
      for (int k = 0; k < queries; k++)
        send_word(CMD_QUERY, pick_coord(wide || $urandom_range(0, 7) == 0, span),
                  pick_coord(wide || $urandom_range(0, 7) == 0, span));
    end
    steady = 1'b0;
    req.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
